// ===== hw/rtl/bmm_pkg.sv =====
package bmm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_BLOCK_EDGE   = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	// register widths and reset values
	localparam int unsigned CFG_W = 13;
	localparam int unsigned IDX_W = 2;
	localparam logic [CFG_W-1:0] EDGE_RESET   = 13'd0;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd256;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd256;

	// geometry limits
	localparam logic [CFG_W-1:0] DIM_LIMIT = 13'd4096;
	localparam logic [CFG_W-1:0] MIN_EDGE  = 13'd3;

	// max(w,h)/12 as a multiply by a reciprocal, exact for values up to 4096
	localparam int unsigned     RECIP_W    = 14;
	localparam logic [13:0]     AUTO_RECIP = 14'd10923;
	localparam int unsigned     AUTO_SHIFT = 17;

	// stream field widths
	localparam int unsigned IN_W    = 16;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned SLICE_W = 10;
	localparam int unsigned COL_W   = 5;
	localparam int unsigned VAL_W   = 16;
	localparam int unsigned FIELDS_W = SLICE_W + COORD_W + COL_W + 4 * VAL_W;
	localparam int unsigned TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

	// controller to datapath
	typedef struct packed {
		logic setup_edge;
		logic setup_step;
		logic accept;
		logic commit;
		logic flip;
		logic row_adv;
		logic slice_adv;
		logic emit;
		logic use_brow;
		logic last;
	} bmm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cfg_hit;
		logic cols_done;
		logic row_end;
		logic emit_prev;
		logic flip_need;
		logic last_row;
		logic k_last;
		logic out_free;
	} bmm_stat_t;

endpackage

// ===== hw/rtl/block_min_max_map.sv =====
// Block min/max map: takes one unsigned sample per beat in raster order (column, row,
// slice) and tiles each slice into square blocks of side B that also take in one row
// and one column of their right and lower neighbors. After the last row of a band of
// blocks it sends one result beat per block, left to right, with the block's min and
// max and the running global extremes; tlast marks the last result a sample causes.
// Samples inside a row are taken at one per cycle. After the last sample of a row
// s_tready stays low while the final block segment is committed and the result beats
// go out: one per block, ceil(W/B) capped at MAX_BLOCK_COLS, for each finished band
// (two when the last row of a slice also opens a band after the first), sent one
// at a time through the single read port of the band store and one output register.
// After reset and each register write the geometry is set up with s_tready low.
// A register write restarts the current slice; slice count and global extremes remain.
module block_min_max_map
	import bmm_pkg::*;
#(
	parameter int unsigned MAX_BLOCK_COLS = 32,
	parameter int unsigned SAMPLE_BITS    = 16,
	parameter int unsigned MAX_SLICES     = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // [15:0] sample
	output logic               m_tvalid,
	input  logic               m_tready,
	// [9:0] slice_index, [21:10] block_row, [26:22] block_col, [42:27] block_min,
	// [58:43] block_max, [74:59] global_min, [90:75] global_max, rest zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast,   // last_of_run
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	bmm_cmd_t  cmd;
	bmm_stat_t stat;

	// sequencing of setup, sample accept, commit and band emission
	bmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// counters, band stores, extremes and output register
	bmm_dpath #(
		.MAX_BLOCK_COLS (MAX_BLOCK_COLS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.MAX_SLICES     (MAX_SLICES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hw/rtl/bmm_ctrl.sv =====
module bmm_ctrl
	import bmm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  bmm_stat_t stat,
	output bmm_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_SETUP_EDGE = 6'b000001,
		ST_SETUP_COLS = 6'b000010,
		ST_IDLE       = 6'b000100,
		ST_COMMIT     = 6'b001000,
		ST_EMIT_PREV  = 6'b010000,
		ST_EMIT_LAST  = 6'b100000
	} state_t;

	state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SETUP_EDGE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_SETUP_EDGE: begin
				cmd.setup_edge = 1'b1;
				state_n = ST_SETUP_COLS;
			end
			ST_SETUP_COLS: begin
				cmd.setup_step = 1'b1;
				if (stat.cols_done) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (stat.row_end) begin
						state_n = ST_COMMIT;
					end
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				if (stat.emit_prev) begin
					state_n = ST_EMIT_PREV;
				end else begin
					cmd.flip = stat.flip_need;
					if (stat.last_row) begin
						state_n = ST_EMIT_LAST;
					end else begin
						cmd.row_adv = 1'b1;
						state_n = ST_IDLE;
					end
				end
			end
			ST_EMIT_PREV: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = stat.k_last && !stat.last_row;
					if (stat.k_last) begin
						cmd.flip = 1'b1;
						if (stat.last_row) begin
							state_n = ST_EMIT_LAST;
						end else begin
							cmd.row_adv = 1'b1;
							state_n = ST_IDLE;
						end
					end
				end
			end
			ST_EMIT_LAST: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.use_brow = 1'b1;
					if (stat.k_last) begin
						cmd.last      = 1'b1;
						cmd.slice_adv = 1'b1;
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_SETUP_EDGE;
			end
		endcase
		// a register write restarts the geometry setup
		if (stat.cfg_hit) begin
			state_n = ST_SETUP_EDGE;
		end
	end

endmodule

// ===== hw/rtl/bmm_dpath.sv =====
module bmm_dpath
	import bmm_pkg::*;
#(
	parameter int unsigned MAX_BLOCK_COLS = 32,
	parameter int unsigned SAMPLE_BITS    = 16,
	parameter int unsigned MAX_SLICES     = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bmm_cmd_t           cmd,
	output bmm_stat_t          stat,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast
);

	localparam int unsigned SW  = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
	localparam int unsigned CW  = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
	localparam int unsigned BXW = CW + 1;
	localparam int unsigned SLW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int unsigned PROD_W = CFG_W + RECIP_W;
	localparam logic [BXW-1:0] MAX_COLS  = BXW'(MAX_BLOCK_COLS);
	localparam logic [CW-1:0]  LAST_SLOT = CW'(MAX_BLOCK_COLS - 1);
	localparam logic [SLW-1:0] LAST_SLICE = SLW'(MAX_SLICES - 1);

	// configuration registers
	logic [CFG_W-1:0] edge_q, width_q, height_q;
	// geometry settled at setup
	logic [CFG_W-1:0] b_q, w_q, h_q;
	logic [CFG_W:0]   acc_q;
	logic [BXW-1:0]   cnt_q, nemit_q;
	// position counters
	logic [COORD_W-1:0] x_q, offx_q, y_q, offy_q, brow_q;
	logic [BXW-1:0]     bx_q;
	logic [SLW-1:0]     slice_q;
	logic [CW-1:0]      k_q, slot_q;
	logic               sel_q;
	// running segment of the current block within the row
	logic [SW-1:0] seg_min_q, seg_max_q;
	// two band stores, one holds the band being finished, the other the next
	logic [SW-1:0] a_min_q [MAX_BLOCK_COLS];
	logic [SW-1:0] a_max_q [MAX_BLOCK_COLS];
	logic [SW-1:0] b_min_q [MAX_BLOCK_COLS];
	logic [SW-1:0] b_max_q [MAX_BLOCK_COLS];
	// global extremes
	logic [SW-1:0] glow_q, ghigh_q;
	// output register fields
	logic               out_valid_q, out_last_q;
	logic [SLICE_W-1:0] out_slice_q;
	logic [COORD_W-1:0] out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic [SW-1:0]      out_bmin_q, out_bmax_q, out_gmin_q, out_gmax_q;

	logic [SW-1:0] s;
	logic cfg_hit;

	assign s = s_tdata[SW-1:0];
	assign cfg_hit = cfg_we && (cfg_index == REG_BLOCK_EDGE ||
		cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q   <= EDGE_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_EDGE:   edge_q   <= cfg_data;
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// block edge: clamp dimensions, pick automatic size, enforce minimum
	logic [CFG_W-1:0]  w_c, h_c, dmax, be, auto_edge, b_pick, b_fin;
	logic [PROD_W-1:0] prod;

	always_comb begin
		w_c = (width_q == '0) ? CFG_W'(1) : ((width_q > DIM_LIMIT) ? DIM_LIMIT : width_q);
		h_c = (height_q == '0) ? CFG_W'(1) : ((height_q > DIM_LIMIT) ? DIM_LIMIT : height_q);
		dmax = (w_c > h_c) ? w_c : h_c;
		prod = PROD_W'(dmax) * PROD_W'(AUTO_RECIP);
		auto_edge = CFG_W'(prod >> AUTO_SHIFT);
		be = (edge_q > DIM_LIMIT) ? DIM_LIMIT : edge_q;
		b_pick = (be == '0) ? auto_edge : be;
		b_fin = (b_pick < MIN_EDGE) ? MIN_EDGE : b_pick;
	end

	// block column count by repeated addition of the edge
	logic [CFG_W:0] acc_n;
	logic [BXW-1:0] cnt_n;

	assign acc_n = acc_q + (CFG_W+1)'(b_q);
	assign cnt_n = cnt_q + BXW'(1);

	always_ff @(posedge clk) begin
		if (cmd.setup_edge) begin
			b_q   <= b_fin;
			w_q   <= w_c;
			h_q   <= h_c;
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.setup_step) begin
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			nemit_q <= cnt_n;
		end
	end

	// position decode
	logic bx_lt_max, seg_start, seg_bnd, row_end, offx_wrap, offy_wrap;
	logic cur_active, next_active;
	logic [CW-1:0] cur_slot;

	always_comb begin
		bx_lt_max   = bx_q < MAX_COLS;
		cur_slot    = bx_lt_max ? bx_q[CW-1:0] : LAST_SLOT;
		seg_start   = (offx_q == '0) && bx_lt_max;
		seg_bnd     = seg_start && (x_q != '0);
		row_end     = (CFG_W'(x_q) + CFG_W'(1)) >= w_q;
		offx_wrap   = (CFG_W'(offx_q) + CFG_W'(1)) >= b_q;
		offy_wrap   = (CFG_W'(offy_q) + CFG_W'(1)) >= b_q;
		next_active = offy_q == '0;
		cur_active  = (offy_q != '0) || (y_q != '0);
	end

	// single read port on the band stores
	logic [CW-1:0] rd_addr;
	logic [SW-1:0] rd_min, rd_max;

	always_comb begin
		priority if (cmd.accept) begin
			rd_addr = bx_q[CW-1:0] - CW'(1);
		end else if (cmd.commit) begin
			rd_addr = slot_q;
		end else begin
			rd_addr = k_q;
		end
		rd_min = sel_q ? b_min_q[rd_addr] : a_min_q[rd_addr];
		rd_max = sel_q ? b_max_q[rd_addr] : a_max_q[rd_addr];
	end

	// segment merge and commit into the band stores
	logic [SW-1:0] val_min, val_max, cur_min, cur_max;
	logic commit_en, wr_cur, wr_next;

	always_comb begin
		if (cmd.commit) begin
			val_min = seg_min_q;
			val_max = seg_max_q;
		end else begin
			val_min = (s < seg_min_q) ? s : seg_min_q;
			val_max = (s > seg_max_q) ? s : seg_max_q;
		end
		cur_min   = (val_min < rd_min) ? val_min : rd_min;
		cur_max   = (val_max > rd_max) ? val_max : rd_max;
		commit_en = (cmd.accept && seg_bnd) || cmd.commit;
		wr_cur    = commit_en && cur_active;
		wr_next   = commit_en && next_active;
	end

	always_ff @(posedge clk) begin
		if (wr_cur) begin
			if (sel_q) begin
				b_min_q[rd_addr] <= cur_min;
				b_max_q[rd_addr] <= cur_max;
			end else begin
				a_min_q[rd_addr] <= cur_min;
				a_max_q[rd_addr] <= cur_max;
			end
		end
		if (wr_next) begin
			if (sel_q) begin
				a_min_q[rd_addr] <= val_min;
				a_max_q[rd_addr] <= val_max;
			end else begin
				b_min_q[rd_addr] <= val_min;
				b_max_q[rd_addr] <= val_max;
			end
		end
	end

	// segment register and the slot it belongs to
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seg_min_q <= seg_start ? s : val_min;
			seg_max_q <= seg_start ? s : val_max;
			if (row_end) begin
				slot_q <= cur_slot;
			end
		end
	end

	// counters
	logic k_last;
	assign k_last = (BXW'(k_q) + BXW'(1)) == nemit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			offx_q  <= '0;
			bx_q    <= '0;
			y_q     <= '0;
			offy_q  <= '0;
			brow_q  <= '0;
			slice_q <= '0;
			k_q     <= '0;
			sel_q   <= 1'b0;
		end else if (cfg_hit) begin
			x_q    <= '0;
			offx_q <= '0;
			bx_q   <= '0;
			y_q    <= '0;
			offy_q <= '0;
			brow_q <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.accept) begin
				if (row_end) begin
					x_q    <= '0;
					offx_q <= '0;
					bx_q   <= '0;
				end else begin
					x_q <= x_q + COORD_W'(1);
					if (offx_wrap) begin
						offx_q <= '0;
						if (bx_lt_max) begin
							bx_q <= bx_q + BXW'(1);
						end
					end else begin
						offx_q <= offx_q + COORD_W'(1);
					end
				end
			end
			if (cmd.flip) begin
				sel_q <= !sel_q;
			end
			if (cmd.row_adv) begin
				y_q <= y_q + COORD_W'(1);
				if (offy_wrap) begin
					offy_q <= '0;
					brow_q <= brow_q + COORD_W'(1);
				end else begin
					offy_q <= offy_q + COORD_W'(1);
				end
			end
			if (cmd.slice_adv) begin
				y_q     <= '0;
				offy_q  <= '0;
				brow_q  <= '0;
				slice_q <= (slice_q == LAST_SLICE) ? '0 : slice_q + SLW'(1);
			end
			if (cmd.emit) begin
				k_q <= k_last ? '0 : k_q + CW'(1);
			end
		end
	end

	// running global extremes including the block being emitted
	logic [SW-1:0] glow_n, ghigh_n;
	assign glow_n  = (rd_min < glow_q) ? rd_min : glow_q;
	assign ghigh_n = (rd_max > ghigh_q) ? rd_max : ghigh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glow_q  <= '1;
			ghigh_q <= '0;
		end else if (cmd.emit) begin
			glow_q  <= glow_n;
			ghigh_q <= ghigh_n;
		end
	end

	// output register
	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_slice_q <= SLICE_W'(slice_q);
			out_row_q   <= cmd.use_brow ? brow_q : brow_q - COORD_W'(1);
			out_col_q   <= COL_W'(k_q);
			out_bmin_q  <= rd_min;
			out_bmax_q  <= rd_max;
			out_gmin_q  <= glow_n;
			out_gmax_q  <= ghigh_n;
			out_last_q  <= cmd.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(TDATA_W - FIELDS_W)'(0), VAL_W'(out_gmax_q), VAL_W'(out_gmin_q),
		VAL_W'(out_bmax_q), VAL_W'(out_bmin_q), out_col_q, out_row_q, out_slice_q};

	// status to the controller
	always_comb begin
		stat.cfg_hit   = cfg_hit;
		stat.cols_done = (acc_n >= (CFG_W+1)'(w_q)) || (cnt_n == MAX_COLS);
		stat.row_end   = row_end;
		stat.emit_prev = (offy_q == '0) && (y_q != '0);
		stat.flip_need = offy_q == '0;
		stat.last_row  = (CFG_W'(y_q) + CFG_W'(1)) >= h_q;
		stat.k_last    = k_last;
		stat.out_free  = out_free;
	end

endmodule

// ===== test/tb_block_min_max_map.sv =====
`timescale 1ns / 100ps

module tb_block_min_max_map;
	import bmm_pkg::*;

	localparam int unsigned BAND_COLS     = 32;
	localparam int unsigned SLICE_COUNT   = 1024;
	localparam int unsigned AUTO_DIV      = 12;
	localparam int unsigned RESET_CYCLES  = 11;
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned RX_HOLD       = 600;
	localparam int unsigned RANDOM_ITEMS  = 220;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	// index with no register behind it
	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [SLICE_W-1:0] slice_index;
		logic [COORD_W-1:0] block_row;
		logic [COL_W-1:0]   block_col;
		logic [VAL_W-1:0]   block_min;
		logic [VAL_W-1:0]   block_max;
		logic [VAL_W-1:0]   global_min;
		logic [VAL_W-1:0]   global_max;
		logic               last_of_run;
	} map_beat_t;

	typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_kind_t;

	typedef struct packed {
		step_kind_t       kind;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] value;
		logic [IN_W-1:0]  sample;
		logic             known;
		map_beat_t        want;
	} step_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	// typed expectation that travels with the offered sample
	logic               beat_known = 1'b0;
	map_beat_t          beat_typed = '0;

	bit          rx_hold_req = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;

	block_min_max_map #(
		.MAX_BLOCK_COLS(BAND_COLS),
		.SAMPLE_BITS(16),
		.MAX_SLICES(SLICE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// block map predictor state
	logic [CFG_W-1:0] cfg_edge = EDGE_RESET;
	logic [CFG_W-1:0] cfg_width = WIDTH_RESET;
	logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;
	logic [VAL_W-1:0] cur_lo [BAND_COLS] = '{default: '0};
	logic [VAL_W-1:0] cur_hi [BAND_COLS] = '{default: '0};
	logic [VAL_W-1:0] nxt_lo [BAND_COLS] = '{default: '0};
	logic [VAL_W-1:0] nxt_hi [BAND_COLS] = '{default: '0};
	int unsigned      col_no = 0, row_no = 0, slice_no = 0, off_x = 0, off_y = 0;
	logic [VAL_W-1:0] g_lo = '1;
	logic [VAL_W-1:0] g_hi = '0;

	// block results still owed by the block, oldest first
	map_beat_t due_blocks [$];

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return v;
	endfunction

	function automatic int unsigned col_slot(input int unsigned bx);
		return (bx >= BAND_COLS) ? BAND_COLS - 1 : bx;
	endfunction

	function automatic void widen(input bit to_next, input int unsigned k,
			input logic [VAL_W-1:0] s);
		if (to_next) begin
			if (s < nxt_lo[k]) nxt_lo[k] = s;
			if (s > nxt_hi[k]) nxt_hi[k] = s;
		end else begin
			if (s < cur_lo[k]) cur_lo[k] = s;
			if (s > cur_hi[k]) cur_hi[k] = s;
		end
	endfunction

	// one result per block of the finished band, folding into the global extremes
	function automatic void close_band(input int unsigned brow, input int unsigned n);
		map_beat_t r;
		for (int unsigned k = 0; k < n; k++) begin
			if (cur_lo[k] < g_lo) g_lo = cur_lo[k];
			if (cur_hi[k] > g_hi) g_hi = cur_hi[k];
			r.slice_index = SLICE_W'(slice_no);
			r.block_row = COORD_W'(brow);
			r.block_col = COL_W'(k);
			r.block_min = cur_lo[k];
			r.block_max = cur_hi[k];
			r.global_min = g_lo;
			r.global_max = g_hi;
			r.last_of_run = 1'b0;
			due_blocks.push_back(r);
		end
	endfunction

	function automatic void map_sample(input logic [VAL_W-1:0] s);
		int unsigned w, h, b, ncols, nemit, x, y, bx, i, ip, had;
		bit shared_col;
		had = due_blocks.size();
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		b = (cfg_edge > DIM_LIMIT) ? DIM_LIMIT : cfg_edge;
		if (b == 0)
			b = ((w > h) ? w : h) / AUTO_DIV;
		if (b < MIN_EDGE)
			b = MIN_EDGE;
		ncols = (w + b - 1) / b;
		nemit = (ncols > BAND_COLS) ? BAND_COLS : ncols;
		x = col_no;
		y = row_no;
		bx = x / b;
		i = col_slot(bx);
		ip = col_slot((bx > 0) ? bx - 1 : 0);
		shared_col = (off_x == 0) && (x > 0);

		// first row of a band opens the next band and still closes the current one
		if (off_y == 0) begin
			if (off_x == 0 && bx < BAND_COLS) begin
				nxt_lo[i] = s;
				nxt_hi[i] = s;
			end else begin
				widen(1'b1, i, s);
			end
			if (shared_col) widen(1'b1, ip, s);
			if (y > 0) begin
				widen(1'b0, i, s);
				if (shared_col) widen(1'b0, ip, s);
			end
		end else begin
			widen(1'b0, i, s);
			if (shared_col) widen(1'b0, ip, s);
		end

		// row, band and slice bookkeeping
		if (x + 1 >= w) begin
			col_no = 0;
			off_x = 0;
			if (off_y == 0) begin
				if (y > 0) close_band(y / b - 1, nemit);
				cur_lo = nxt_lo;
				cur_hi = nxt_hi;
			end
			if (y + 1 >= h) begin
				close_band(y / b, nemit);
				row_no = 0;
				off_y = 0;
				slice_no = (slice_no + 1 >= SLICE_COUNT) ? 0 : slice_no + 1;
			end else begin
				row_no = y + 1;
				off_y = (off_y + 1 >= b) ? 0 : off_y + 1;
			end
		end else begin
			col_no = x + 1;
			off_x = (off_x + 1 >= b) ? 0 : off_x + 1;
		end

		if (due_blocks.size() > had)
			due_blocks[due_blocks.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic void match_field(input string what, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// predictor and scoreboard, all sampled at the rising edge
	always @(posedge clk) begin
		map_beat_t got, want;
		int unsigned had;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_EDGE:   cfg_edge = cfg_data;
					REG_IMAGE_WIDTH:  cfg_width = cfg_data;
					REG_IMAGE_HEIGHT: cfg_height = cfg_data;
					default: ;
				endcase
				if (cfg_index != REG_NONE) begin
					col_no = 0;
					row_no = 0;
					off_x = 0;
					off_y = 0;
				end
			end

			if (s_tvalid && s_tready) begin
				had = due_blocks.size();
				map_sample(s_tdata);
				if (beat_known) begin
					while (due_blocks.size() > had)
						void'(due_blocks.pop_back());
					due_blocks.push_back(beat_typed);
				end
			end

			if (m_tvalid && m_tready) begin
				got.slice_index = m_tdata[9:0];
				got.block_row = m_tdata[21:10];
				got.block_col = m_tdata[26:22];
				got.block_min = m_tdata[42:27];
				got.block_max = m_tdata[58:43];
				got.global_min = m_tdata[74:59];
				got.global_max = m_tdata[90:75];
				got.last_of_run = m_tlast;
				if (due_blocks.size() == 0) begin
					$display("%0t: expected no result beat, got %h last %b",
						$time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = due_blocks.pop_front();
					match_field("slice_index", want.slice_index, got.slice_index);
					match_field("block_row", want.block_row, got.block_row);
					match_field("block_col", want.block_col, got.block_col);
					match_field("block_min", want.block_min, got.block_min);
					match_field("block_max", want.block_max, got.block_max);
					match_field("global_min", want.global_min, got.global_min);
					match_field("global_max", want.global_max, got.global_max);
					match_field("last_of_run", want.last_of_run, got.last_of_run);
				end
			end
		end
	end

	// receiver: changing stall patterns plus one long hold-off on request
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_mode_left = 0;
	int unsigned hold_left = 0;
	bit          rx_hold_done = 1'b0;
	logic [1:0]  rx_tick = '0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_hold_req && !rx_hold_done) begin
			rx_hold_done <= 1'b1;
			hold_left <= RX_HOLD;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_mode_left <= $urandom_range(32, 256);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			rx_tick <= rx_tick + 1'b1;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_EVERY4: m_tready <= (rx_tick == 2'd0);
				default:   m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("block_min_max_map regression: fail");
			$finish;
		end
	end

	function automatic logic [IN_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return IN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// offer one sample beat, in bursts with random gaps between them
	task automatic offer(input logic [IN_W-1:0] v, input logic known, input map_beat_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= v;
		beat_known <= known;
		beat_typed <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait until every owed result is in, plus the commit tail
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_blocks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	step_t script [$];

	initial begin
		int unsigned e, w, h, area, n, done_items;

		// 1x1 image: each sample is a whole slice with one block
		script.push_back('{STEP_WRITE, REG_IMAGE_WIDTH, 13'd0, 16'h0, 1'b0, '0});
		script.push_back('{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd0, 16'h0, 1'b0, '0});
		script.push_back('{STEP_SAMPLE, REG_NONE, 13'd0, 16'h0000, 1'b1,
			'{10'd0, 12'd0, 5'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}});
		script.push_back('{STEP_SAMPLE, REG_NONE, 13'd0, 16'hFFFF, 1'b1,
			'{10'd1, 12'd0, 5'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1}});
		script.push_back('{STEP_SAMPLE, REG_NONE, 13'd0, 16'h8001, 1'b1,
			'{10'd2, 12'd0, 5'd0, 16'h8001, 16'h8001, 16'h0000, 16'hFFFF, 1'b1}});

		// 4x4 with edge raised to 3: last row opens a band and closes the slice
		script.push_back('{STEP_WRITE, REG_BLOCK_EDGE, 13'd1, 16'h0, 1'b0, '0});
		script.push_back('{STEP_WRITE, REG_IMAGE_WIDTH, 13'd4, 16'h0, 1'b0, '0});
		script.push_back('{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd4, 16'h0, 1'b0, '0});
		for (int j = 0; j < 16; j++) begin
			// a write to the unused index must not restart the slice
			if (j == 4)
				script.push_back('{STEP_WRITE, REG_NONE, 13'h1FFF, 16'h0, 1'b0, '0});
			script.push_back('{STEP_SAMPLE, REG_NONE, 13'd0,
				16'((j % 2) ? j * 16'h1111 : (15 - j) * 16'h1111), 1'b0, '0});
		end

		// oversized edge on a 1x1 image
		script.push_back('{STEP_WRITE, REG_BLOCK_EDGE, 13'h1FFF, 16'h0, 1'b0, '0});
		script.push_back('{STEP_WRITE, REG_IMAGE_WIDTH, 13'd0, 16'h0, 1'b0, '0});
		script.push_back('{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd0, 16'h0, 1'b0, '0});
		script.push_back('{STEP_SAMPLE, REG_NONE, 13'd0, 16'h1234, 1'b1,
			'{10'd4, 12'd0, 5'd0, 16'h1234, 16'h1234, 16'h0000, 16'hFFFF, 1'b1}});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].kind == STEP_WRITE)
				write_reg(script[k].idx, script[k].value);
			else
				offer(script[k].sample, script[k].known, script[k].want);
		end

		// more block columns than accumulators, a full band at each slice end;
		// the receiver holds off across the first slice end, then the sender
		// waits for every owed result
		write_reg(REG_BLOCK_EDGE, 13'd3);
		write_reg(REG_IMAGE_WIDTH, 13'd100);
		write_reg(REG_IMAGE_HEIGHT, 13'd1);
		for (int j = 0; j < 200; j++) begin
			if (j == 20)
				rx_hold_req <= 1'b1;
			if (j == 100)
				settle();
			offer(pick_sample(), 1'b0, '0);
		end

		// random geometries, mostly small
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					e = $urandom_range(0, 7);
					w = $urandom_range(0, 20);
					h = $urandom_range(0, 10);
				end
				6, 7: begin
					e = $urandom_range(2, 4);
					w = $urandom_range(60, 130);
					h = $urandom_range(1, 5);
				end
				8: begin
					e = 0;
					w = $urandom_range(24, 60);
					h = $urandom_range(1, 8);
				end
				default: begin
					e = $urandom_range(0, 8191);
					w = $urandom_range(0, 12);
					h = $urandom_range(0, 6);
				end
			endcase
			write_reg(REG_BLOCK_EDGE, CFG_W'(e));
			write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
			write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
			area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			n = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
			if (n > 120)
				n = 120;
			repeat (n) offer(pick_sample(), 1'b0, '0);
			done_items += n;
		end

		settle();
		if (mismatches == 0 && due_blocks.size() == 0)
			$display("block_min_max_map regression: pass");
		else
			$display("block_min_max_map regression: fail");
		$finish;
	end

endmodule

// ===== block_min_max_map.f =====
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_ctrl.sv
hw/rtl/bmm_dpath.sv
hw/rtl/block_min_max_map.sv
test/tb_block_min_max_map.sv
